[hdl/wrapping_big_endian_data_memory_unit_macros.svh]
// assertion macros shared by the checker of the data memory unit
`ifndef WRAPPING_BIG_ENDIAN_DATA_MEMORY_UNIT_MACROS_SVH
`define WRAPPING_BIG_ENDIAN_DATA_MEMORY_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define WBEDM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("data memory unit: same-cycle rule broken");

// next-cycle implication, sampled on clk, quiet during reset
`define WBEDM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("data memory unit: next-cycle rule broken");

`endif

[hdl/wbedm_pkg.sv]
// shared constants and types of the wrapping big-endian data memory unit
package wbedm_pkg;

	// default memory size in bytes, a power of two from 16 up
	localparam int MEM_BYTES_DEF = 4096;

	// byte lanes, one memory bank each
	localparam int LANES = 8;

	// access kinds
	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_STORE = 1'b1
	} op_t;

	// per-bank access strobes for one cycle
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} bank_ctl_t;

endpackage

[hdl/wrapping_big_endian_data_memory_unit.sv]
// top level: byte-addressed big-endian data memory over eight byte-lane banks
// a response word appears in the cycle after its request word is taken
// throughput: one load or store per cycle while not stalled, one port per lane bank
// every byte of an access lands in a different bank, so any alignment takes one pass
// reset clears only the response valid; memory contents are undefined until written
// MEM_BYTES must be a power of two, at least 16
module wrapping_big_endian_data_memory_unit #(
	parameter int MEM_BYTES = wbedm_pkg::MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        op,
	input  logic [1:0]  size_code,
	input  logic [11:0] byte_address,
	input  logic [63:0] write_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [63:0] read_data
);

	localparam int AW    = $clog2(MEM_BYTES);
	localparam int ROW_W = AW - 3;
	localparam int LANES = wbedm_pkg::LANES;

	logic [AW-1:0]    addr;
	logic [2:0]       lane0;
	logic [ROW_W-1:0] row0;
	logic [3:0]       nbytes;
	logic             accept;
	logic             is_store;

	wbedm_pkg::bank_ctl_t ctl   [LANES];
	logic [ROW_W-1:0]     row   [LANES];
	logic [7:0]           wbyte [LANES];
	logic [7:0]           rbyte [LANES];

	logic       valid_s1;
	logic       store_s1;
	logic [3:0] nbytes_s1;
	logic [2:0] lane0_s1;

	// address folded into the memory, split into lane and row
	assign addr     = AW'(byte_address);
	assign lane0    = addr[2:0];
	assign row0     = addr[AW-1:3];
	assign nbytes   = 4'd1 << size_code;
	assign is_store = (op == wbedm_pkg::OP_STORE);

	// a new word waits only while a response is held up
	assign req_stall = valid_s1 & rsp_stall;
	assign accept    = req_valid & ~req_stall;

	// per-bank row, strobes and store byte
	for (genvar b = 0; b < LANES; b++) begin : g_lane
		logic [2:0] k;
		logic [2:0] sel;
		logic       active;

		// offset of this bank's byte within the access
		assign k      = 3'(b) - lane0;
		assign active = {1'b0, k} < nbytes;
		assign sel    = 3'(nbytes - 4'd1 - {1'b0, k});
		// banks below the start lane hold the bytes of the next row, wrapping at the top
		assign row[b] = (3'(b) < lane0) ? row0 + ROW_W'(1) : row0;
		// most significant used byte goes to the start address
		assign wbyte[b] = write_data[{sel, 3'b000} +: 8];

		assign ctl[b].wr_en = accept & is_store & active;
		assign ctl[b].rd_en = accept & ~is_store;

		wbedm_bank #(
			.ROW_W (ROW_W)
		) u_bank (
			.clk   (clk),
			.ctl   (ctl[b]),
			.row   (row[b]),
			.wdata (wbyte[b]),
			.rdata (rbyte[b])
		);
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	// access shape kept for reassembly
	always_ff @(posedge clk) begin
		if (accept) begin
			store_s1  <= is_store;
			nbytes_s1 <= nbytes;
			lane0_s1  <= lane0;
		end
	end

	// gather bank bytes into a right-justified big-endian word, zero for a store
	for (genvar p = 0; p < LANES; p++) begin : g_out
		logic [2:0] idx;
		logic [2:0] lane;
		logic       used;

		assign used = (4'(p) < nbytes_s1) & ~store_s1;
		assign idx  = 3'(nbytes_s1 - 4'd1 - 4'(p));
		assign lane = lane0_s1 + idx;
		assign read_data[8*p +: 8] = used ? rbyte[lane] : 8'h00;
	end

	assign rsp_valid = valid_s1;

endmodule

[hdl/wbedm_bank.sv]
// one byte-lane bank: synchronous single-port ram with registered read
module wbedm_bank #(
	parameter int ROW_W = 9
) (
	input  logic                   clk,
	input  wbedm_pkg::bank_ctl_t   ctl,
	input  logic [ROW_W-1:0]       row,
	input  logic [7:0]             wdata,
	output logic [7:0]             rdata
);

	localparam int ROWS = 1 << ROW_W;

	logic [7:0] mem [ROWS];

	// write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[row] <= wdata;
		end
	end

	// read port, data held while not enabled
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata <= mem[row];
		end
	end

endmodule

[hdl/wbedm_checker.sv]
// port-level checker of the data memory unit and its bind
`include "wrapping_big_endian_data_memory_unit_macros.svh"

module wbedm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        op,
	input logic [63:0] write_data,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [63:0] read_data
);

	// a held response keeps its data
	`WBEDM_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, $stable(read_data))

	// every accepted word gives a response on the next cycle
	`WBEDM_ASSERT_NXT(a_rsp_follows, req_valid && !req_stall, rsp_valid)

	// a store answers with zero
	`WBEDM_ASSERT_NXT(a_store_zero, req_valid && !req_stall && op, read_data == 64'h0)

	// no new word is taken while a response waits
	`WBEDM_ASSERT_IMP(a_stall_back, rsp_valid && rsp_stall, req_stall)

	// with no response pending the request side is open
	`WBEDM_ASSERT_IMP(a_open_when_empty, !rsp_valid, !req_stall)

endmodule

bind wrapping_big_endian_data_memory_unit wbedm_checker u_wbedm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_stall  (req_stall),
	.op         (op),
	.write_data (write_data),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.read_data  (read_data)
);

[bench/wrapping_big_endian_data_memory_unit_checker.sv]
// predicts and compares every read word of the wrapping big-endian data memory unit
module wrapping_big_endian_data_memory_unit_checker
	import wbedm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic        op,
	input  logic [1:0]  size_code,
	input  logic [11:0] byte_address,
	input  logic [63:0] write_data,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [63:0] read_data,
	output logic [31:0] pending,
	output int          failures
);
	timeunit 1ns;
	timeprecision 1ps;

	// private copy of the memory contents
	logic [7:0]  mirror_bytes [MEM_BYTES_DEF];
	// read data still owed by the block, oldest first
	logic [63:0] owed_read_data [$];
	logic [63:0] oldest_owed;

	initial failures = 0;

	// one line per mismatch, and a count of them
	task automatic report_mismatch(string what, logic [63:0] seen, logic [63:0] wanted);
		$display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, seen, wanted);
		failures++;
	endtask

	// apply one access to the copy; loads give bytes most significant first
	function automatic logic [63:0] big_endian_access(op_t kind, logic [1:0] sz,
			logic [11:0] addr, logic [63:0] data);
		int unsigned count;
		int unsigned k;
		int unsigned spot;
		logic [63:0] loaded;
		count = 1 << sz;
		loaded = '0;
		for (k = 0; k < count; k++) begin
			spot = (addr + k) % MEM_BYTES_DEF;
			if (kind == OP_LOAD) begin
				loaded = {loaded[55:0], mirror_bytes[spot]};
			end else begin
				mirror_bytes[spot] = data[8 * (count - 1 - k) +: 8];
			end
		end
		return loaded;
	endfunction

	// compare taken response words, then predict for taken request words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_read_data.delete();
			pending <= '0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_read_data.size() == 0) begin
					report_mismatch("unrequested response word", read_data, 'x);
				end else begin
					oldest_owed = owed_read_data.pop_front();
					if (read_data !== oldest_owed) begin
						report_mismatch("read_data", read_data, oldest_owed);
					end
				end
			end
			if (req_valid && !req_stall) begin
				owed_read_data.push_back(big_endian_access(op_t'(op), size_code,
					byte_address, write_data));
			end
			pending <= owed_read_data.size();
		end
	end

endmodule

[bench/wrapping_big_endian_data_memory_unit_test.sv]
// stimulus and verdict for the wrapping big-endian data memory unit
module wrapping_big_endian_data_memory_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import wbedm_pkg::*;

	localparam int RANDOM_WORDS = 1600;
	localparam int CYCLE_LIMIT  = 200000;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        req_valid    = 1'b0;
	logic        req_stall;
	op_t         op           = OP_LOAD;
	logic [1:0]  size_code    = '0;
	logic [11:0] byte_address = '0;
	logic [63:0] write_data   = '0;
	logic        rsp_valid;
	logic        rsp_stall    = 1'b1;
	logic [63:0] read_data;
	logic [31:0] pending;
	int          failures;
	int          cycle_count;

	// no idling on either side while set
	bit          calm = 1'b0;
	// bytes stored since reset, so that loads only touch written bytes
	bit          written [MEM_BYTES_DEF];
	logic [11:0] last_store = '0;

	wrapping_big_endian_data_memory_unit DUT (.*);

	wrapping_big_endian_data_memory_unit_checker access_check (.*);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// response side: stall a random number of cycles before each word
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 7);
			@(negedge clk);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
		end
	end

	// present one request word after a random gap, hold it until taken
	task automatic issue_access(op_t kind, logic [1:0] sz, logic [11:0] addr,
			logic [63:0] data);
		int gap;
		int k;
		gap = calm ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		op           <= kind;
		size_code    <= sz;
		byte_address <= addr;
		write_data   <= data;
		req_valid    <= 1'b1;
		if (kind == OP_STORE) begin
			for (k = 0; k < (1 << sz); k++) written[12'(addr + k)] = 1'b1;
			last_store = addr;
		end
		do @(posedge clk); while (!(req_valid && !req_stall));
	endtask

	// stop sending until every owed response word has come back
	task automatic await_all_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	// addresses near the last store, near the wrap point, or anywhere
	function automatic logic [11:0] aim_address();
		case ($urandom_range(0, 3))
			0, 1: return last_store + 12'($urandom_range(0, 8)) - 12'd4;
			2: return 12'd4088 + 12'($urandom_range(0, 15));
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	// main stimulus
	initial begin
		int n;
		int tries;
		int k;
		logic [1:0] sz;
		logic [11:0] a;
		bit found;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed: accesses of every width at the wrap point
		issue_access(OP_STORE, 2'd3, 12'd4092, 64'h0123_4567_89ab_cdef);
		issue_access(OP_LOAD,  2'd3, 12'd4092, 64'h0);
		issue_access(OP_LOAD,  2'd2, 12'd4094, 64'hffff_ffff_ffff_ffff);
		issue_access(OP_LOAD,  2'd1, 12'd4095, 64'h0);
		issue_access(OP_LOAD,  2'd0, 12'd4095, 64'h0);
		issue_access(OP_LOAD,  2'd0, 12'd0,    64'h0);
		// directed: unused store bits set, extremes of data
		issue_access(OP_STORE, 2'd0, 12'd0,    64'hffff_ffff_ffff_ffff);
		issue_access(OP_LOAD,  2'd3, 12'd4092, 64'h0);
		issue_access(OP_STORE, 2'd1, 12'd4095, 64'hffff_ffff_ffff_a55a);
		issue_access(OP_LOAD,  2'd2, 12'd4093, 64'h0);
		issue_access(OP_STORE, 2'd2, 12'd2,    64'h0);
		issue_access(OP_LOAD,  2'd3, 12'd4092, 64'h0);
		issue_access(OP_STORE, 2'd3, 12'd4,    64'hffff_ffff_ffff_ffff);
		issue_access(OP_LOAD,  2'd3, 12'd0,    64'h0);
		issue_access(OP_LOAD,  2'd2, 12'd8,    64'h0);
		issue_access(OP_LOAD,  2'd1, 12'd6,    64'h0);
		issue_access(OP_LOAD,  2'd0, 12'd11,   64'h0);
		// directed: mid-memory, unaligned partial overlap
		issue_access(OP_STORE, 2'd3, 12'h800,  64'h8000_0000_0000_0001);
		issue_access(OP_LOAD,  2'd3, 12'h800,  64'h0);
		issue_access(OP_LOAD,  2'd0, 12'h807,  64'h0);
		issue_access(OP_LOAD,  2'd2, 12'h802,  64'h0);
		issue_access(OP_STORE, 2'd2, 12'h7fe,  64'hdead_beef_cafe_f00d);
		issue_access(OP_LOAD,  2'd1, 12'h7ff,  64'h0);
		await_all_results();

		// random: loads only where every byte has been written
		for (n = 0; n < RANDOM_WORDS; n++) begin
			calm = (n % 256) >= 192;
			if (n == RANDOM_WORDS / 2 || $urandom_range(0, 299) == 0) begin
				await_all_results();
			end
			sz = 2'($urandom_range(0, 3));
			found = 1'b0;
			if ($urandom_range(0, 99) < 55) begin
				for (tries = 0; tries < 32 && !found; tries++) begin
					a = aim_address();
					found = 1'b1;
					for (k = 0; k < (1 << sz); k++) found &= written[12'(a + k)];
				end
			end
			if (found) begin
				issue_access(OP_LOAD, sz, a, {$urandom, $urandom});
			end else begin
				issue_access(OP_STORE, sz, aim_address(), {$urandom, $urandom});
			end
		end

		// drain, let the pipeline settle, then give the verdict
		await_all_results();
		repeat (8) @(posedge clk);
		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// cycle limit
	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
+incdir+hdl
hdl/wbedm_pkg.sv
hdl/wbedm_bank.sv
hdl/wrapping_big_endian_data_memory_unit.sv
hdl/wbedm_checker.sv
bench/wrapping_big_endian_data_memory_unit_checker.sv
bench/wrapping_big_endian_data_memory_unit_test.sv
